// ===== rtl/matrix_keypad_debounce_scanner_core_assert.svh =====
// Assertion macros for the keypad scanner core.
// Needs signals named clock and reset in the scope of each use.
`ifndef MATRIX_KEYPAD_DEBOUNCE_SCANNER_CORE_ASSERT_SVH
`define MATRIX_KEYPAD_DEBOUNCE_SCANNER_CORE_ASSERT_SVH

// Checked only outside reset
`define MKDS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included
`define MKDS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/mkds_pkg.sv =====
// Shared widths and constants for the keypad scanner core.
// No dependencies.
package mkds_pkg;

   localparam int ROW_IDX_W   = 2;   // row index field
   localparam int COL_IN_W    = 4;   // column level field
   localparam int KEY_W       = 4;   // key index field
   localparam int CNT_W       = 8;   // run counter field; compared with the threshold
   localparam int THR_W       = 8;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd5;
   localparam logic [CNT_W-1:0] COUNTER_TOP     = 8'd255;

endpackage

// ===== rtl/mkds_if.sv =====
// Valid/ready channel interfaces for scan samples and scan results.
// Depends on mkds_pkg for field widths.
interface mkds_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [mkds_pkg::ROW_IDX_W-1:0]       row_index;
   logic [mkds_pkg::COL_IN_W-1:0]        col_levels;
   logic                                 clear_available;

   modport source (output valid, output row_index, output col_levels,
                   output clear_available, input ready);
   modport sink   (input valid, input row_index, input col_levels,
                   input clear_available, output ready);
endinterface

interface mkds_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 key_available;
   logic [mkds_pkg::KEY_W-1:0]           key_index;
   logic                                 new_press;
   logic [mkds_pkg::COL_IN_W-1:0]        row_stable_levels;

   modport source (output valid, output key_available, output key_index,
                   output new_press, output row_stable_levels, input ready);
   modport sink   (input valid, input key_available, input key_index,
                   input new_press, input row_stable_levels, output ready);
endinterface

// ===== rtl/matrix_keypad_debounce_scanner_core.sv =====
// Debounced matrix keypad scanner: per-key run counters, stable levels, key latch.
// Depends on mkds_pkg, mkds_if.sv and matrix_keypad_debounce_scanner_core_assert.svh.
//
// Usage:
//   req_if carries one scan sample per word: the row driven low, the column
//   levels read back (0 = pressed) and a flag that clears the key-available bit.
//   rsp_if returns one result word per sample: sticky key-available flag, last
//   latched key index, a new-press pulse and the debounced levels of that row.
//   csr_write_en/csr_write_data write the debounce threshold (reset value 5);
//   write it only while no sample is in flight.
// Timing:
//   A sample accepted into the input register is processed by one pass of
//   logic and moves into the result register when that register is empty or
//   being read. One sample per cycle is sustained while rsp_if.ready stays
//   high; the per-key state is updated as the sample leaves the input
//   register, so back-to-back samples on the same row see each other's update.
// Reset (synchronous): counters and previous levels clear, stable levels go to
//   released, the key latch and flag clear and both registers empty.
// Stall: when rsp_if.ready is low the result holds, the input register keeps
//   one more sample, then req_if.ready drops.
module matrix_keypad_debounce_scanner_core #(
   parameter int ROW_COUNT = 4,
   parameter int COL_COUNT = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [mkds_pkg::THR_W-1:0]    csr_write_data,
   mkds_req_if.sink                      req_if,
   mkds_rsp_if.source                    rsp_if
);

`include "matrix_keypad_debounce_scanner_core_assert.svh"

   localparam int ROW_IDX_W = mkds_pkg::ROW_IDX_W;
   localparam int COL_IN_W  = mkds_pkg::COL_IN_W;
   localparam int KEY_W     = mkds_pkg::KEY_W;
   localparam int CNT_W     = mkds_pkg::CNT_W;
   localparam int THR_W     = mkds_pkg::THR_W;

   // threshold register
   logic [THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mkds_pkg::THRESHOLD_RESET;
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   // input register
   logic                  s1_vld_ff;
   logic [ROW_IDX_W-1:0]  s1_row_ff;
   logic [COL_IN_W-1:0]   s1_cols_ff;
   logic                  s1_clr_ff;
   logic                  load_res;
   logic                  req_take;

   // result register
   logic                  rsp_vld_ff;
   logic                  avail_ff;
   logic [KEY_W-1:0]      key_ff;
   logic                  press_ff;
   logic [COL_IN_W-1:0]   levels_ff;

   assign load_res   = s1_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !s1_vld_ff || load_res;
   assign req_take   = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_take) begin
         s1_vld_ff <= 1'b1;
      end else if (load_res) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_row_ff  <= req_if.row_index;
         s1_cols_ff <= req_if.col_levels;
         s1_clr_ff  <= req_if.clear_available;
      end
   end

   // per-key state, one row vector per keypad row
   logic [COL_COUNT-1:0] prev_ff   [ROW_COUNT];
   logic [COL_COUNT-1:0] stable_ff [ROW_COUNT];
   logic [CNT_W-1:0]     cnt_ff    [ROW_COUNT][COL_COUNT];

   logic [COL_COUNT-1:0] prev_in   [ROW_COUNT];
   logic [COL_COUNT-1:0] stable_in [ROW_COUNT];
   logic [CNT_W-1:0]     cnt_in    [ROW_COUNT][COL_COUNT];

   logic                 row_ok;
   logic [COL_COUNT-1:0] cur_prev;
   logic [COL_COUNT-1:0] cur_stable;
   logic [CNT_W-1:0]     cur_cnt   [COL_COUNT];
   logic [COL_COUNT-1:0] new_prev;
   logic [COL_COUNT-1:0] new_stable;
   logic [CNT_W-1:0]     new_cnt   [COL_COUNT];
   logic                 press_c;
   logic [KEY_W-1:0]     key_c;
   logic [COL_IN_W-1:0]  levels_c;
   logic                 avail_c;

   // select the sampled row
   always_comb begin
      row_ok     = 32'(s1_row_ff) < ROW_COUNT;
      cur_prev   = '0;
      cur_stable = '1;
      for (int c = 0; c < COL_COUNT; c++) begin
         cur_cnt[c] = '0;
      end
      for (int r = 0; r < ROW_COUNT; r++) begin
         if (32'(s1_row_ff) == r) begin
            cur_prev   = prev_ff[r];
            cur_stable = stable_ff[r];
            for (int c = 0; c < COL_COUNT; c++) begin
               cur_cnt[c] = cnt_ff[r][c];
            end
         end
      end
   end

   // per-key counter update; highest qualifying column wins the latch
   always_comb begin
      logic lvl;
      logic upd;
      press_c    = 1'b0;
      key_c      = key_ff;
      new_prev   = cur_prev;
      new_stable = cur_stable;
      for (int c = 0; c < COL_COUNT; c++) begin
         lvl = (c < COL_IN_W) ? s1_cols_ff[c[1:0]] : 1'b1;
         if (lvl == cur_prev[c]) begin
            upd        = cur_cnt[c] != mkds_pkg::COUNTER_TOP;
            new_cnt[c] = upd ? cur_cnt[c] + 1'b1 : cur_cnt[c];
         end else begin
            upd        = 1'b1;
            new_cnt[c] = '0;
         end
         if (upd && new_cnt[c] == thr_ff) begin
            new_stable[c] = lvl;
            if (!lvl && row_ok) begin
               press_c = 1'b1;
               key_c   = KEY_W'(32'(s1_row_ff) * COL_COUNT + c);
            end
         end
         new_prev[c] = lvl;
      end
   end

   // result fields
   always_comb begin
      levels_c = '0;
      if (row_ok) begin
         levels_c = '1;
         for (int c = 0; c < COL_COUNT; c++) begin
            if (c < COL_IN_W && !new_stable[c]) begin
               levels_c[c[1:0]] = 1'b0;
            end
         end
      end
      avail_c = (avail_ff && !s1_clr_ff) || press_c;
   end

   // state write-back for the sampled row
   always_comb begin
      prev_in   = prev_ff;
      stable_in = stable_ff;
      cnt_in    = cnt_ff;
      if (load_res && row_ok) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            if (32'(s1_row_ff) == r) begin
               prev_in[r]   = new_prev;
               stable_in[r] = new_stable;
               for (int c = 0; c < COL_COUNT; c++) begin
                  cnt_in[r][c] = new_cnt[c];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            prev_ff[r]   <= '0;
            stable_ff[r] <= '1;
            for (int c = 0; c < COL_COUNT; c++) begin
               cnt_ff[r][c] <= '0;
            end
         end
      end else begin
         prev_ff   <= prev_in;
         stable_ff <= stable_in;
         cnt_ff    <= cnt_in;
      end
   end

   // key latch and sticky flag, plus result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         avail_ff   <= 1'b0;
         key_ff     <= '0;
      end else begin
         if (load_res) begin
            rsp_vld_ff <= 1'b1;
            avail_ff   <= avail_c;
            key_ff     <= key_c;
         end else if (rsp_if.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_res) begin
         press_ff  <= press_c;
         levels_ff <= levels_c;
      end
   end

   assign rsp_if.valid             = rsp_vld_ff;
   assign rsp_if.key_available     = avail_ff;
   assign rsp_if.key_index         = key_ff;
   assign rsp_if.new_press         = press_ff;
   assign rsp_if.row_stable_levels = levels_ff;

   // checks
   `MKDS_ASSERT(a_press_sets_flag, rsp_vld_ff && press_ff |-> avail_ff,
      "new press reported without key available")
   `MKDS_ASSERT(a_press_latches, load_res && press_c |=> avail_ff && key_ff == $past(key_c),
      "debounced press not latched")
   `MKDS_ASSERT(a_input_held, s1_vld_ff && !load_res |=> s1_vld_ff && $stable(s1_row_ff),
      "stalled sample lost from input register")
   `MKDS_ASSERT_ALWAYS(a_reset_empty, reset |=> !s1_vld_ff && !rsp_vld_ff && !avail_ff,
      "registers not empty after reset")

endmodule

// ===== test/tb_matrix_keypad_debounce_scanner_core.sv =====
// Testbench for the debounced keypad scanner core: scan words against a debounce predictor.
// Depends on mkds_pkg, mkds_if.sv and matrix_keypad_debounce_scanner_core.sv.
module tb_matrix_keypad_debounce_scanner_core;

   localparam int ROW_IDX_W = mkds_pkg::ROW_IDX_W;
   localparam int COL_IN_W  = mkds_pkg::COL_IN_W;
   localparam int KEY_W     = mkds_pkg::KEY_W;
   localparam int CNT_W     = mkds_pkg::CNT_W;
   localparam int THR_W     = mkds_pkg::THR_W;

   localparam int ROWS = 4;
   localparam int COLS = 4;
   localparam int KEYS = ROWS * COLS;

   // one scan sample as driven on the request channel
   typedef struct packed {
      logic [ROW_IDX_W-1:0] row;
      logic [COL_IN_W-1:0]  cols;
      logic                 clr;
   } scan_word_type;

   // one result word as seen on the response channel
   typedef struct packed {
      logic                avail;
      logic [KEY_W-1:0]    key;
      logic                press;
      logic [COL_IN_W-1:0] levels;
   } scan_result_type;

   // directed row: sample, whether a result is typed in, and that result
   typedef struct packed {
      scan_word_type   word;
      logic            typed;
      scan_result_type result;
   } script_row_type;

   localparam int WORD_W = $bits(scan_word_type);

   logic             clock;
   logic             reset;
   logic             csr_write_en;
   logic [THR_W-1:0] csr_write_data;

   mkds_req_if sample_ch ();
   mkds_rsp_if result_ch ();

   matrix_keypad_debounce_scanner_core #(
      .ROW_COUNT (ROWS),
      .COL_COUNT (COLS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_if         (sample_ch),
      .rsp_if         (result_ch)
   );

   // predictor state: per-key raw level, run counter and debounced level
   logic             prev_lvl   [KEYS];
   logic [CNT_W-1:0] run_cnt    [KEYS];
   logic             stable_lvl [KEYS];
   logic [KEY_W-1:0] latched_key;
   logic             key_flag;
   logic [THR_W-1:0] threshold;

   scan_result_type results_due [$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              recv_idle_pct  = 0;
   logic [KEYS-1:0] held_keys      = '0;   // 1 = key held down on the virtual keypad
   int              scan_row       = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // debounce one sample of a row and return the result word it should produce
   function automatic scan_result_type debounce_sample(input scan_word_type w);
      scan_result_type  r;
      int               k;
      logic             lvl;
      logic [CNT_W-1:0] cnt;
      logic             moved;
      r.press  = 1'b0;
      r.levels = '1;
      // clear comes first, so a press in the same sample leaves the flag set
      if (w.clr) key_flag = 1'b0;
      for (int c = 0; c < COLS; c++) begin
         k   = int'(w.row) * COLS + c;
         lvl = w.cols[c];
         if (lvl == prev_lvl[k]) begin
            // saturating count; a held counter is not an update
            cnt   = (run_cnt[k] != mkds_pkg::COUNTER_TOP) ? run_cnt[k] + 1'b1 : run_cnt[k];
            moved = (cnt != run_cnt[k]);
         end else begin
            cnt   = '0;
            moved = 1'b1;
         end
         run_cnt[k] = cnt;
         if (moved && cnt == threshold) begin
            stable_lvl[k] = lvl;
            // ascending loop, so the highest column of the row wins
            if (!lvl) begin
               key_flag    = 1'b1;
               latched_key = k[KEY_W-1:0];
               r.press     = 1'b1;
            end
         end
         prev_lvl[k] = lvl;
         if (!stable_lvl[k]) r.levels[c] = 1'b0;
      end
      r.avail = key_flag;
      r.key   = latched_key;
      return r;
   endfunction

   // drive one word, wait for the handshake, then queue what it should give
   task automatic send_sample(input scan_word_type w, input logic typed,
                              input scan_result_type typed_res);
      scan_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         sample_ch.valid <= 1'b0;
         @(posedge clock);
      end
      sample_ch.valid           <= 1'b1;
      sample_ch.row_index       <= w.row;
      sample_ch.col_levels      <= w.cols;
      sample_ch.clear_available <= w.clr;
      @(posedge clock);
      while (!sample_ch.ready) @(posedge clock);
      predicted = debounce_sample(w);
      results_due.push_back(typed ? typed_res : predicted);
   endtask

   // threshold write once the core has drained; every sample gives a result
   task automatic retune(input logic [THR_W-1:0] value);
      sample_ch.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      threshold    = value;
   endtask

   // scan a virtual keypad row by row, with key changes, contact bounce and noise
   task automatic scan_keypad(input int count);
      scan_word_type w;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(11) == 0) held_keys[$urandom_range(KEYS-1)] ^= 1'b1;
         w.row = ($urandom_range(9) == 0) ? ROW_IDX_W'($urandom_range(ROWS-1))
                                          : ROW_IDX_W'(scan_row);
         scan_row = (int'(w.row) + 1) % ROWS;
         w.cols   = ~held_keys[int'(w.row)*COLS +: COLS];
         if ($urandom_range(7) == 0) w.cols[$urandom_range(COLS-1)] ^= 1'b1;
         w.clr = ($urandom_range(5) == 0);
         if ($urandom_range(15) == 0) w = WORD_W'($urandom);
         send_sample(w, 1'b0, '0);
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker: each accepted word against the oldest expectation
   always @(posedge clock) begin
      scan_result_type due;
      if (!reset && result_ch.valid && result_ch.ready) begin
         if (results_due.size() == 0) begin
            $display("%0t: result word with nothing outstanding, expected none actual %0h",
                     $time, {result_ch.key_available, result_ch.key_index,
                             result_ch.new_press, result_ch.row_stable_levels});
            mismatch_count++;
         end else begin
            due = results_due.pop_front();
            check_field("key_available", 8'(due.avail), 8'(result_ch.key_available));
            check_field("key_index", 8'(due.key), 8'(result_ch.key_index));
            check_field("new_press", 8'(due.press), 8'(result_ch.new_press));
            check_field("row_stable_levels", 8'(due.levels),
                        8'(result_ch.row_stable_levels));
         end
      end
   end

   // stimulus
   initial begin
      script_row_type script [19];
      scan_word_type  w;
      // row, cols, clr | typed | avail, key, press, levels
      script = '{
         '{'{2'd0, 4'hF, 1'b0}, 1'b1, '{1'b0, 4'h0, 1'b0, 4'hF}},   // fresh from reset
         '{'{2'd1, 4'hB, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hB, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hB, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hB, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hB, 1'b0}, 1'b1, '{1'b1, 4'h6, 1'b1, 4'hB}},   // press latched
         '{'{2'd1, 4'hB, 1'b0}, 1'b1, '{1'b1, 4'h6, 1'b0, 4'hB}},   // reported once
         '{'{2'd3, 4'h6, 1'b0}, 1'b0, '0},
         '{'{2'd3, 4'h6, 1'b0}, 1'b0, '0},
         '{'{2'd3, 4'h6, 1'b0}, 1'b0, '0},
         '{'{2'd3, 4'h6, 1'b0}, 1'b0, '0},
         '{'{2'd3, 4'h6, 1'b1}, 1'b1, '{1'b1, 4'hF, 1'b1, 4'h6}},   // clear with press, top column
         '{'{2'd2, 4'h0, 1'b1}, 1'b1, '{1'b0, 4'hF, 1'b0, 4'hF}},   // plain clear
         '{'{2'd1, 4'hF, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hF, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hF, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hF, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hF, 1'b0}, 1'b0, '0},
         '{'{2'd1, 4'hF, 1'b0}, 1'b1, '{1'b0, 4'hF, 1'b0, 4'hF}}    // release settles
      };

      reset                     <= 1'b1;
      csr_write_en              <= 1'b0;
      csr_write_data            <= '0;
      sample_ch.valid           <= 1'b0;
      sample_ch.row_index       <= '0;
      sample_ch.col_levels      <= '0;
      sample_ch.clear_available <= 1'b0;
      for (int k = 0; k < KEYS; k++) begin
         prev_lvl[k]   = 1'b0;
         run_cnt[k]    = '0;
         stable_lvl[k] = 1'b1;
      end
      latched_key = '0;
      key_flag    = 1'b0;
      threshold   = mkds_pkg::THRESHOLD_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // sender slow, receiver slower
      send_idle_pct = 28;
      recv_idle_pct = 46;
      foreach (script[i]) send_sample(script[i].word, script[i].typed, script[i].result);
      retune(8'd3);
      scan_keypad(130);
      retune(8'd1);
      scan_keypad(110);

      // roles swapped
      send_idle_pct = 46;
      recv_idle_pct = 28;
      // top threshold: one row held long enough for the counters to saturate
      retune(mkds_pkg::COUNTER_TOP);
      w.row  = ROW_IDX_W'($urandom_range(ROWS-1));
      w.cols = COL_IN_W'($urandom_range(14));
      for (int i = 0; i < 280; i++) begin
         w.clr = ($urandom_range(7) == 0);
         send_sample(w, 1'b0, '0);
      end
      retune(THR_W'($urandom_range(9, 2)));
      scan_keypad(130);

      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      retune(8'd8);
      scan_keypad(130);

      sample_ch.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("matrix_keypad_debounce_scanner_core regression: pass");
      else
         $display("matrix_keypad_debounce_scanner_core regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #3000000;
      $display("matrix_keypad_debounce_scanner_core regression: fail");
      $finish;
   end

endmodule
